/* src/mclp_pkg.sv */
// Types and constants shared by the motion command line parser modules.
package mclp_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_LIMIT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTENSION_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGHEST_CHANNEL = 2'd2;

  localparam logic [15:0] AXIS_LIMIT_RESET      = 16'd9999;
  localparam logic [23:0] EXTENSION_LIMIT_RESET = 24'd99999;
  localparam logic [3:0]  HIGHEST_CHANNEL_RESET = 4'd9;

  localparam logic [23:0] ACC_MAX = 24'hFFFFFF;

  // character codes
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP  = 8'h20;

  localparam logic [2:0] CLS_NONE   = 3'd0;
  localparam logic [2:0] CLS_AXIS   = 3'd1;
  localparam logic [2:0] CLS_DEVICE = 3'd2;
  localparam logic [2:0] CLS_SETUP  = 3'd3;
  localparam logic [2:0] CLS_EXT    = 3'd4;

  localparam logic [2:0] KIND_NONE      = 3'd0;
  localparam logic [2:0] KIND_LINEAR    = 3'd1;
  localparam logic [2:0] KIND_ROTATION  = 3'd2;
  localparam logic [2:0] KIND_VIBRATION = 3'd3;
  localparam logic [2:0] KIND_AUX       = 3'd4;

  localparam logic [1:0] EXT_NONE     = 2'd0;
  localparam logic [1:0] EXT_INTERVAL = 2'd1;
  localparam logic [1:0] EXT_SPEED    = 2'd2;

  localparam logic [2:0] RAMP_NONE     = 3'd0;
  localparam logic [2:0] RAMP_LINEAR   = 3'd1;
  localparam logic [2:0] RAMP_EASE_IN  = 3'd2;
  localparam logic [2:0] RAMP_EASE_OUT = 3'd3;
  localparam logic [2:0] RAMP_IN_OUT   = 3'd4;

  localparam logic [2:0] DEV_NONE     = 3'd0;
  localparam logic [2:0] DEV_STOP     = 3'd1;
  localparam logic [2:0] DEV_SW_VER   = 3'd2;
  localparam logic [2:0] DEV_PROTO    = 3'd3;
  localparam logic [2:0] DEV_AXIS_VAL = 3'd4;

  typedef enum logic [13:0] {
    PH_FIRST   = 14'h0001,
    PH_AX_CHAN = 14'h0002,
    PH_AX_VAL  = 14'h0004,
    PH_AX_EXT  = 14'h0008,
    PH_AX_LT   = 14'h0010,
    PH_AX_DONE = 14'h0020,
    PH_SU_TYPE = 14'h0040,
    PH_SU_CHAN = 14'h0080,
    PH_SU_SEP  = 14'h0100,
    PH_SU_MIN  = 14'h0200,
    PH_SU_MAX  = 14'h0400,
    PH_SU_DONE = 14'h0800,
    PH_DEV_OP  = 14'h1000,
    PH_IGNORE  = 14'h2000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [2:0]  cmd_class;
    logic        cmd_valid;
    logic [2:0]  chan_kind;
    logic [7:0]  chan_number;
    logic [15:0] axis_value;
    logic [1:0]  ext_kind;
    logic [23:0] ext_value;
    logic [2:0]  ramp_kind;
    logic [15:0] range_low;
    logic [15:0] range_high;
    logic [2:0]  device_op;
  } out_t;

  typedef struct packed {
    phase_t      phase;
    logic [23:0] acc;
    logic        seen;
    logic        err;
    logic [2:0]  cls;
    logic [2:0]  kind;
    logic [7:0]  chan;
    logic [1:0]  ekind;
    logic [2:0]  ramp;
    logic [2:0]  dev;
    logic [15:0] val;
    logic [23:0] ext_val;
    logic [15:0] rhigh;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:   PH_FIRST,
    acc:     24'd0,
    seen:    1'b0,
    err:     1'b0,
    cls:     CLS_NONE,
    kind:    KIND_NONE,
    chan:    8'd0,
    ekind:   EXT_NONE,
    ramp:    RAMP_NONE,
    dev:     DEV_NONE,
    val:     16'd0,
    ext_val: 24'd0,
    rhigh:   16'd0
  };

endpackage

/* src/mclp_step.sv */
// One character step of the parse state: phase advance, digit accumulate, field capture.
module mclp_step import mclp_pkg::*; (
  input  parse_t      cur,
  input  logic [7:0]  ch,
  input  logic        fin,
  input  logic [15:0] axis_limit,
  input  logic [23:0] ext_limit,
  output parse_t      nxt
);

  logic [7:0]  uc;
  logic        is_dig;
  logic [27:0] prod;
  logic [23:0] acc_dig;
  logic [23:0] num;
  logic [15:0] num_ax;
  logic [23:0] num_ext;
  logic [2:0]  kind_c;

  assign uc     = (ch >= CH_LOW_A && ch <= CH_LOW_Z) ? ch - CASE_GAP : ch;
  assign is_dig = !fin && ch >= CH_0 && ch <= CH_9;

  // acc * 10 + digit, saturating at 24 bits
  assign prod    = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {24'd0, ch[3:0]};
  assign acc_dig = (|prod[27:24]) ? ACC_MAX : prod[23:0];

  assign num     = cur.seen ? cur.acc : 24'd0;
  assign num_ax  = (num > {8'd0, axis_limit}) ? axis_limit : num[15:0];
  assign num_ext = (num > ext_limit) ? ext_limit : num;

  always_comb begin
    case (uc)
      CH_L:    kind_c = KIND_LINEAR;
      CH_R:    kind_c = KIND_ROTATION;
      CH_V:    kind_c = KIND_VIBRATION;
      CH_A:    kind_c = KIND_AUX;
      default: kind_c = KIND_NONE;
    endcase
  end

  // ramp suffix or trailing garbage after the value / extension
  function automatic parse_t after_ext(parse_t p, logic [7:0] c, logic f);
    parse_t q;
    q = p;
    if (!f) begin
      q.phase = PH_AX_DONE;
      case (c)
        CH_LT: begin
          q.ramp  = RAMP_EASE_IN;
          q.phase = PH_AX_LT;
        end
        CH_GT:   q.ramp = RAMP_EASE_OUT;
        CH_EQ:   q.ramp = RAMP_LINEAR;
        default: q.err = 1'b1;
      endcase
    end
    return q;
  endfunction

  always_comb begin
    nxt = cur;
    unique case (cur.phase)
      PH_FIRST: begin
        case (uc) inside
          CH_L, CH_R, CH_V, CH_A: begin
            nxt.cls   = CLS_AXIS;
            nxt.kind  = kind_c;
            nxt.ramp  = RAMP_LINEAR;
            nxt.phase = PH_AX_CHAN;
          end
          CH_D: begin
            nxt.cls   = CLS_DEVICE;
            nxt.phase = PH_DEV_OP;
          end
          CH_DOLLAR: begin
            nxt.cls   = CLS_SETUP;
            nxt.phase = PH_SU_TYPE;
          end
          CH_HASH: begin
            nxt.cls   = CLS_EXT;
            nxt.phase = PH_IGNORE;
          end
          default: begin
            nxt.err   = 1'b1;
            nxt.phase = PH_IGNORE;
          end
        endcase
      end
      PH_AX_CHAN: begin
        nxt.chan  = ch - CH_0;
        nxt.acc   = 24'd0;
        nxt.seen  = 1'b0;
        nxt.phase = PH_AX_VAL;
      end
      PH_AX_VAL: begin
        if (is_dig) begin
          nxt.acc  = acc_dig;
          nxt.seen = 1'b1;
        end else begin
          nxt.val  = num_ax;
          nxt.err  = cur.err | !cur.seen;
          nxt.acc  = 24'd0;
          nxt.seen = 1'b0;
          if (!fin && (uc == CH_I || uc == CH_S)) begin
            nxt.ekind = (uc == CH_I) ? EXT_INTERVAL : EXT_SPEED;
            nxt.phase = PH_AX_EXT;
          end else begin
            nxt = after_ext(nxt, ch, fin);
          end
        end
      end
      PH_AX_EXT: begin
        if (is_dig) begin
          nxt.acc  = acc_dig;
          nxt.seen = 1'b1;
        end else begin
          nxt.ext_val = num_ext;
          nxt.err     = cur.err | !cur.seen;
          nxt.acc     = 24'd0;
          nxt.seen    = 1'b0;
          nxt         = after_ext(nxt, ch, fin);
        end
      end
      PH_AX_LT: begin
        if (!fin) begin
          if (ch == CH_GT) nxt.ramp = RAMP_IN_OUT;
          else             nxt.err  = 1'b1;
          nxt.phase = PH_AX_DONE;
        end
      end
      PH_AX_DONE, PH_SU_DONE: begin
        if (!fin) nxt.err = 1'b1;
      end
      PH_SU_TYPE: begin
        // end of line here clears the kind and takes the channel as ch minus the '0' code
        nxt.kind = fin ? KIND_NONE : kind_c;
        if (fin) nxt.chan = ch - CH_0;
        nxt.phase = PH_SU_CHAN;
      end
      PH_SU_CHAN: begin
        nxt.chan  = ch - CH_0;
        nxt.phase = PH_SU_SEP;
      end
      PH_SU_SEP: begin
        if (fin || ch != CH_DASH) nxt.err = 1'b1;
        nxt.acc   = 24'd0;
        nxt.seen  = 1'b0;
        nxt.phase = PH_SU_MIN;
      end
      PH_SU_MIN: begin
        if (is_dig) begin
          nxt.acc  = acc_dig;
          nxt.seen = 1'b1;
        end else begin
          nxt.val   = num_ax;
          nxt.err   = cur.err | !cur.seen | fin | (ch != CH_DASH);
          nxt.acc   = 24'd0;
          nxt.seen  = 1'b0;
          nxt.phase = PH_SU_MAX;
        end
      end
      PH_SU_MAX: begin
        if (is_dig) begin
          nxt.acc  = acc_dig;
          nxt.seen = 1'b1;
        end else begin
          nxt.rhigh = num_ax;
          nxt.err   = cur.err | !cur.seen | !fin;
          nxt.acc   = 24'd0;
          nxt.seen  = 1'b0;
          nxt.phase = PH_SU_DONE;
        end
      end
      PH_DEV_OP: begin
        if (fin) begin
          nxt.err = 1'b1;
        end else begin
          case (uc)
            CH_S:    nxt.dev = DEV_STOP;
            CH_0:    nxt.dev = DEV_SW_VER;
            CH_1:    nxt.dev = DEV_PROTO;
            CH_2:    nxt.dev = DEV_AXIS_VAL;
            default: nxt.err = 1'b1;
          endcase
        end
        nxt.phase = PH_IGNORE;
      end
      default: ;
    endcase
  end

endmodule

/* src/mclp_result.sv */
// Final validity checks and per-class field selection of a finished command.
module mclp_result import mclp_pkg::*; (
  input  parse_t     p,
  input  logic [3:0] highest_channel,
  output out_t       res
);

  logic chan_ok;
  logic valid;

  assign chan_ok = (p.kind != KIND_NONE) && (p.chan <= {4'd0, highest_channel});

  always_comb begin
    valid = !p.err;
    case (p.cls)
      CLS_AXIS:  if (!chan_ok) valid = 1'b0;
      CLS_SETUP: if (!chan_ok || p.val > p.rhigh) valid = 1'b0;
      CLS_NONE:  valid = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    res           = '0;
    res.cmd_class = p.cls;
    res.cmd_valid = valid;
    case (p.cls)
      CLS_AXIS: begin
        res.chan_kind   = p.kind;
        res.chan_number = p.chan;
        res.axis_value  = p.val;
        res.ext_kind    = p.ekind;
        res.ext_value   = p.ext_val;
        res.ramp_kind   = p.ramp;
      end
      CLS_SETUP: begin
        res.chan_kind   = p.kind;
        res.chan_number = p.chan;
        res.range_low   = p.val;
        res.range_high  = p.rhigh;
      end
      CLS_DEVICE: res.device_op = p.dev;
      default: ;
    endcase
  end

endmodule

/* src/motion_command_line_parser.sv */
// Top level of the motion command line parser: handshake, registers and parse state.
//
// Feed one command byte per request on in_data (ch, last_char) with in_valid/in_ready.
// Letters are case-insensitive. The byte flagged last_char closes the command and one
// decoded result comes out on out_data with out_valid/out_ready; other bytes give none.
// Timing: a byte taken is held in the input register; when it advances it is folded into the parse
// state, and for a last byte the result is loaded into the output register at the same edge,
// visible from then on. Throughput: one byte per cycle while no final byte waits; the
// combinational parse step (one decimal multiply-accumulate and clamp) sets that figure.
// When out_ready is low with a result pending, non-final bytes still flow in; a final
// byte waits in the input register until the output register frees, and in_ready drops.
// Configuration: cfg_write with cfg_index 0 axis_limit, 1 extension_limit,
// 2 highest_channel, data on the low bits of cfg_data; other indexes are ignored.
// Reset (rst, synchronous): limits return to 9999, 99999 and 9, the parse starts at
// the first byte of a command, and both registers are empty.
module motion_command_line_parser import mclp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_t                    in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_t                   out_data,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0] axis_limit;
  logic [23:0] extension_limit;
  logic [3:0]  highest_channel;

  logic   hold_valid;
  in_t    hold;
  parse_t parse;
  parse_t parse_char;
  parse_t parse_end;
  parse_t parse_next;
  out_t   res;
  logic   slot_free;
  logic   advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_limit      <= AXIS_LIMIT_RESET;
      extension_limit <= EXTENSION_LIMIT_RESET;
      highest_channel <= HIGHEST_CHANNEL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AXIS_LIMIT:      axis_limit      <= cfg_data[15:0];
        REG_EXTENSION_LIMIT: extension_limit <= cfg_data[23:0];
        REG_HIGHEST_CHANNEL: highest_channel <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign slot_free = !out_valid || out_ready;
  assign advance   = hold_valid && (!hold.last_char || slot_free);
  assign in_ready  = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold <= in_data;
    end
  end

  // the byte itself, then the end-of-line step on a zero byte
  mclp_step u_step_char (
    .cur        (parse),
    .ch         (hold.ch),
    .fin        (1'b0),
    .axis_limit (axis_limit),
    .ext_limit  (extension_limit),
    .nxt        (parse_char)
  );

  mclp_step u_step_end (
    .cur        (parse_char),
    .ch         (8'd0),
    .fin        (1'b1),
    .axis_limit (axis_limit),
    .ext_limit  (extension_limit),
    .nxt        (parse_end)
  );

  mclp_result u_result (
    .p               (parse_end),
    .highest_channel (highest_channel),
    .res             (res)
  );

  assign parse_next = hold.last_char ? PARSE_RESET : parse_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      parse <= PARSE_RESET;
    end else if (advance) begin
      parse <= parse_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hold.last_char) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hold.last_char) begin
      out_data <= res;
    end
  end

endmodule
